@@ design/slu3_pkg.sv @@
// Shared widths, types and fixed-point helpers of the 3x3 LU solver.
`timescale 1ns / 1ps
package slu3_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int FRAC_BITS   = 16;
   localparam int PROD_WIDTH  = 2 * DATA_WIDTH;
   localparam int DIV_STEP    = 4;
   localparam int DIV_NQ      = DATA_WIDTH + FRAC_BITS;
   localparam int DIV_STAGES  = (DIV_NQ + DIV_STEP - 1) / DIV_STEP;
   localparam int DIV_NPAD    = DIV_STAGES * DIV_STEP;
   localparam int DIV_LAT     = DIV_STAGES + 2;
   localparam int DIV_LINES   = 5;
   localparam int LINE_A      = 0;
   localparam int LINE_B      = 1;
   localparam int LINE_C      = 2;
   localparam int LINE_D      = 3;
   localparam int LINE_E      = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   typedef logic signed [DATA_WIDTH-1:0] word_type;
   typedef logic [DATA_WIDTH-1:0]        umag_type;

   localparam umag_type NEG_LIM = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam umag_type POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   typedef struct packed {
      word_type val;
      logic     sat;
   } res_type;

   // Item after first pivot selection, as held in the queue
   typedef struct packed {
      logic     sing;
      logic     negdet;
      word_type u00, u01, u02, u10, u11, u12, u20, u21, u22;
      word_type v0, v1, v2;
   } front_rec_type;

   // Working record of the solver pipeline; u10/u20 hold l10/l20 once known
   typedef struct packed {
      logic     vld;
      logic     sing;
      logic     negdet;
      logic     sat;
      word_type u00, u01, u02, u10, u11, u12, u20, u21, u22;
      word_type v0, v1, v2;
      word_type l21, x0, x1, x2;
      word_type t0, t1, t2, t3;
   } rec_type;

   function automatic umag_type mag_f(word_type a);
      umag_type u;
      u = umag_type'(a);
      return a[DATA_WIDTH-1] ? umag_type'(-u) : u;
   endfunction

   // Product shifted right by the fraction bits, truncated toward zero, saturated
   function automatic res_type mul_f(word_type a, word_type b);
      logic                  neg;
      logic [PROD_WIDTH-1:0] p;
      logic [PROD_WIDTH-1:0] s;
      logic [PROD_WIDTH-1:0] lim;
      umag_type              m;
      res_type               r;
      neg   = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
      p     = PROD_WIDTH'(mag_f(a)) * PROD_WIDTH'(mag_f(b));
      s     = p >> FRAC_BITS;
      lim   = neg ? PROD_WIDTH'(NEG_LIM) : PROD_WIDTH'(POS_MAX);
      r.sat = s > lim;
      if (r.sat) begin
         s = lim;
      end
      m     = s[DATA_WIDTH-1:0];
      r.val = neg ? word_type'(-m) : word_type'(m);
      return r;
   endfunction

   // Saturating difference
   function automatic res_type sub_f(word_type a, word_type b);
      logic [DATA_WIDTH:0] d;
      res_type             r;
      d     = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
      r.sat = d[DATA_WIDTH] ^ d[DATA_WIDTH-1];
      if (r.sat) begin
         r.val = d[DATA_WIDTH] ? word_type'(NEG_LIM) : word_type'(POS_MAX);
      end else begin
         r.val = word_type'(d[DATA_WIDTH-1:0]);
      end
      return r;
   endfunction

endpackage

@@ design/slu3_front.sv @@
// Front end: zero-column check and first pivot row selection.
`timescale 1ns / 1ps
module slu3_front (
   input  slu3_pkg::word_type      m00,
   input  slu3_pkg::word_type      m01,
   input  slu3_pkg::word_type      m02,
   input  slu3_pkg::word_type      m10,
   input  slu3_pkg::word_type      m11,
   input  slu3_pkg::word_type      m12,
   input  slu3_pkg::word_type      m20,
   input  slu3_pkg::word_type      m21,
   input  slu3_pkg::word_type      m22,
   input  slu3_pkg::word_type      rhs0,
   input  slu3_pkg::word_type      rhs1,
   input  slu3_pkg::word_type      rhs2,
   output slu3_pkg::front_rec_type rec
);
   import slu3_pkg::*;

   umag_type a0, a1, a2;

   assign a0 = mag_f(m00);
   assign a1 = mag_f(m10);
   assign a2 = mag_f(m20);

   // Pick the largest column-0 magnitude; ties keep the earlier row
   always_comb begin
      rec.sing   = (m00 == '0) && (m10 == '0) && (m20 == '0);
      rec.negdet = 1'b0;
      rec.u00 = m00; rec.u01 = m01; rec.u02 = m02; rec.v0 = rhs0;
      rec.u10 = m10; rec.u11 = m11; rec.u12 = m12; rec.v1 = rhs1;
      rec.u20 = m20; rec.u21 = m21; rec.u22 = m22; rec.v2 = rhs2;
      if ((a0 < a1 && a1 < a2) || (a0 >= a1 && a0 < a2)) begin
         rec.negdet = 1'b1;
         rec.u00 = m20; rec.u01 = m21; rec.u02 = m22; rec.v0 = rhs2;
         rec.u20 = m00; rec.u21 = m01; rec.u22 = m02; rec.v2 = rhs0;
      end else if (a0 < a1) begin
         rec.negdet = 1'b1;
         rec.u00 = m10; rec.u01 = m11; rec.u02 = m12; rec.v0 = rhs1;
         rec.u10 = m00; rec.u11 = m01; rec.u12 = m02; rec.v1 = rhs0;
      end
   end

endmodule

@@ design/slu3_queue.sv @@
// Short queue between the front end and the solver pipeline.
`timescale 1ns / 1ps
module slu3_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  slu3_pkg::front_rec_type wdata,
   output logic                    full,
   input  logic                    pop,
   output slu3_pkg::front_rec_type rdata,
   output logic                    empty
);
   import slu3_pkg::*;

   front_rec_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_AW:0]         count_ff, count_in;
   logic                      do_push, do_pop;

   assign full    = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

endmodule

@@ design/slu3_div.sv @@
// Pipelined restoring divider for saturating fixed-point quotients.
`timescale 1ns / 1ps
module slu3_div (
   input  logic               clock,
   input  logic               en,
   input  slu3_pkg::word_type num,
   input  slu3_pkg::word_type den,
   output slu3_pkg::word_type quo,
   output logic               sat
);
   import slu3_pkg::*;

   typedef struct packed {
      logic                neg;
      logic                zero;
      umag_type            mb;
      umag_type            rem;
      logic [DIV_NPAD-1:0] nsh;
      logic [DIV_NPAD-1:0] q;
   } div_state_type;

   div_state_type st_ff [DIV_STAGES+1];
   div_state_type st_in [DIV_STAGES+1];
   res_type       out_ff, out_in;

   function automatic div_state_type step_f(div_state_type s);
      div_state_type       r;
      logic [DATA_WIDTH:0] t;
      r = s;
      for (int i = 0; i < DIV_STEP; i++) begin
         t     = {r.rem, r.nsh[DIV_NPAD-1]};
         r.nsh = r.nsh << 1;
         if (t >= {1'b0, r.mb}) begin
            t   = t - {1'b0, r.mb};
            r.q = {r.q[DIV_NPAD-2:0], 1'b1};
         end else begin
            r.q = {r.q[DIV_NPAD-2:0], 1'b0};
         end
         r.rem = t[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic res_type finish_f(div_state_type s);
      logic [DIV_NPAD-1:0] lim;
      logic [DIV_NPAD-1:0] qv;
      umag_type            m;
      res_type             r;
      lim = s.neg ? DIV_NPAD'(NEG_LIM) : DIV_NPAD'(POS_MAX);
      qv  = s.q;
      r.sat = !s.zero && (qv > lim);
      if (r.sat) begin
         qv = lim;
      end
      m = qv[DATA_WIDTH-1:0];
      if (s.zero) begin
         r.val = '0;
      end else begin
         r.val = s.neg ? word_type'(-m) : word_type'(m);
      end
      return r;
   endfunction

   // Prepare magnitudes, then run DIV_STEP quotient bits per stage
   always_comb begin
      st_in[0].neg  = num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
      st_in[0].zero = den == '0;
      st_in[0].mb   = mag_f(den);
      st_in[0].rem  = '0;
      st_in[0].nsh  = DIV_NPAD'(mag_f(num)) << FRAC_BITS;
      st_in[0].q    = '0;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         st_in[k] = step_f(st_ff[k-1]);
      end
      out_in = finish_f(st_ff[DIV_STAGES]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            st_ff[k] <= st_in[k];
         end
         out_ff <= out_in;
      end
   end

   assign quo = out_ff.val;
   assign sat = out_ff.sat;

endmodule

@@ design/slu3_back.sv @@
// Back end: elimination, second pivot and substitution pipeline.
`timescale 1ns / 1ps
module slu3_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  slu3_pkg::front_rec_type in_data,
   output logic                    in_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output slu3_pkg::word_type      rsp_sol0,
   output slu3_pkg::word_type      rsp_sol1,
   output slu3_pkg::word_type      rsp_sol2,
   output logic                    rsp_singular,
   output logic                    rsp_det_negative,
   output logic                    rsp_overflow
);
   import slu3_pkg::*;

   logic    en;
   rec_type s0_in, s0_ff, s2_in, s2_ff, s3_in, s3_ff, s4_in, s4_ff;
   rec_type s6_in, s6_ff, s7_in, s7_ff, s8_in, s8_ff, s9_in, s9_ff;
   rec_type s11_in, s11_ff, s12_in, s12_ff, s14_in, s14_ff;
   rec_type s15_in, s15_ff, s16_in, s16_ff, out_in, out_ff;
   rec_type dl_ff [DIV_LINES][DIV_LAT];
   rec_type dl_in [DIV_LINES];
   word_type qa0, qa1, qb, qc, qd, qe;
   logic     sa0, sa1, sb, sc, sd, se;

   // Whole pipeline moves unless a finished result waits
   assign en        = !out_ff.vld || rsp_pop;
   assign in_pop    = en && in_valid;
   assign rsp_empty = !out_ff.vld;

   assign dl_in[LINE_A] = s0_ff;
   assign dl_in[LINE_B] = s4_ff;
   assign dl_in[LINE_C] = s9_ff;
   assign dl_in[LINE_D] = s12_ff;
   assign dl_in[LINE_E] = s16_ff;

   slu3_div u_div_l10 (.clock(clock), .en(en), .num(s0_ff.u10), .den(s0_ff.u00),
                       .quo(qa0), .sat(sa0));
   slu3_div u_div_l20 (.clock(clock), .en(en), .num(s0_ff.u20), .den(s0_ff.u00),
                       .quo(qa1), .sat(sa1));
   slu3_div u_div_l21 (.clock(clock), .en(en), .num(s4_ff.u21), .den(s4_ff.u11),
                       .quo(qb), .sat(sb));
   slu3_div u_div_x2  (.clock(clock), .en(en), .num(s9_ff.v2), .den(s9_ff.u22),
                       .quo(qc), .sat(sc));
   slu3_div u_div_x1  (.clock(clock), .en(en), .num(s12_ff.v1), .den(s12_ff.u11),
                       .quo(qd), .sat(sd));
   slu3_div u_div_x0  (.clock(clock), .en(en), .num(s16_ff.v0), .den(s16_ff.u00),
                       .quo(qe), .sat(se));

   // Stage logic
   always_comb begin
      res_type  r0, r1, r2, r3;
      word_type tw;

      // Load from queue
      s0_in        = '0;
      s0_in.vld    = in_valid;
      s0_in.sing   = in_data.sing;
      s0_in.negdet = in_data.negdet;
      s0_in.u00 = in_data.u00; s0_in.u01 = in_data.u01; s0_in.u02 = in_data.u02;
      s0_in.u10 = in_data.u10; s0_in.u11 = in_data.u11; s0_in.u12 = in_data.u12;
      s0_in.u20 = in_data.u20; s0_in.u21 = in_data.u21; s0_in.u22 = in_data.u22;
      s0_in.v0  = in_data.v0;  s0_in.v1  = in_data.v1;  s0_in.v2  = in_data.v2;

      // Take l10, l20 and form the row-0 products
      s2_in     = dl_ff[LINE_A][DIV_LAT-1];
      s2_in.u10 = qa0;
      s2_in.u20 = qa1;
      r0 = mul_f(s2_in.u01, qa0);
      r1 = mul_f(s2_in.u02, qa0);
      r2 = mul_f(s2_in.u01, qa1);
      r3 = mul_f(s2_in.u02, qa1);
      s2_in.t0  = r0.val; s2_in.t1 = r1.val; s2_in.t2 = r2.val; s2_in.t3 = r3.val;
      s2_in.sat = s2_in.sat | sa0 | sa1 | r0.sat | r1.sat | r2.sat | r3.sat;

      // Eliminate column 0
      s3_in = s2_ff;
      r0 = sub_f(s2_ff.u11, s2_ff.t0);
      r1 = sub_f(s2_ff.u12, s2_ff.t1);
      r2 = sub_f(s2_ff.u21, s2_ff.t2);
      r3 = sub_f(s2_ff.u22, s2_ff.t3);
      s3_in.u11 = r0.val; s3_in.u12 = r1.val; s3_in.u21 = r2.val; s3_in.u22 = r3.val;
      s3_in.sat = s3_in.sat | r0.sat | r1.sat | r2.sat | r3.sat;

      // Second pivot: swap rows 1 and 2 when row 2 is strictly larger
      s4_in = s3_ff;
      if (s3_ff.u11 == '0 && s3_ff.u21 == '0) begin
         s4_in.sing = 1'b1;
      end
      if (mag_f(s3_ff.u11) < mag_f(s3_ff.u21)) begin
         s4_in.negdet = !s3_ff.negdet;
         s4_in.u10 = s3_ff.u20; s4_in.u20 = s3_ff.u10;
         s4_in.u11 = s3_ff.u21; s4_in.u21 = s3_ff.u11;
         s4_in.u12 = s3_ff.u22; s4_in.u22 = s3_ff.u12;
         s4_in.v1  = s3_ff.v2;  s4_in.v2  = s3_ff.v1;
      end

      // Take l21; products for U22 and forward substitution
      s6_in     = dl_ff[LINE_B][DIV_LAT-1];
      s6_in.l21 = qb;
      r0 = mul_f(s6_in.u12, qb);
      r1 = mul_f(s6_in.u10, s6_in.v0);
      r2 = mul_f(s6_in.u20, s6_in.v0);
      s6_in.t0  = r0.val; s6_in.t1 = r1.val; s6_in.t2 = r2.val;
      s6_in.sat = s6_in.sat | sb | r0.sat | r1.sat | r2.sat;

      s7_in = s6_ff;
      r0 = sub_f(s6_ff.u22, s6_ff.t0);
      r1 = sub_f(s6_ff.v1, s6_ff.t1);
      r2 = sub_f(s6_ff.v2, s6_ff.t2);
      s7_in.u22 = r0.val; s7_in.v1 = r1.val; s7_in.v2 = r2.val;
      s7_in.sat = s7_in.sat | r0.sat | r1.sat | r2.sat;

      // Check last pivot; l21 times y1
      s8_in = s7_ff;
      if (s7_ff.u22 == '0) begin
         s8_in.sing = 1'b1;
      end
      r0 = mul_f(s7_ff.l21, s7_ff.v1);
      s8_in.t0  = r0.val;
      s8_in.sat = s8_in.sat | r0.sat;

      s9_in = s8_ff;
      r0 = sub_f(s8_ff.v2, s8_ff.t0);
      s9_in.v2  = r0.val;
      s9_in.sat = s9_in.sat | r0.sat;

      // Take x2 and start back substitution
      s11_in    = dl_ff[LINE_C][DIV_LAT-1];
      s11_in.x2 = qc;
      r0 = mul_f(s11_in.u12, qc);
      r1 = mul_f(s11_in.u02, qc);
      s11_in.t0  = r0.val; s11_in.t1 = r1.val;
      s11_in.sat = s11_in.sat | sc | r0.sat | r1.sat;

      s12_in = s11_ff;
      r0 = sub_f(s11_ff.v1, s11_ff.t0);
      s12_in.v1  = r0.val;
      s12_in.sat = s12_in.sat | r0.sat;

      // Take x1
      s14_in    = dl_ff[LINE_D][DIV_LAT-1];
      s14_in.x1 = qd;
      r0 = mul_f(s14_in.u01, qd);
      s14_in.t0  = r0.val;
      s14_in.sat = s14_in.sat | sd | r0.sat;

      s15_in = s14_ff;
      r0 = sub_f(s14_ff.v0, s14_ff.t0);
      s15_in.v0  = r0.val;
      s15_in.sat = s15_in.sat | r0.sat;

      s16_in = s15_ff;
      r0 = sub_f(s15_ff.v0, s15_ff.t1);
      s16_in.v0  = r0.val;
      s16_in.sat = s16_in.sat | r0.sat;

      // Take x0 into the result register
      tw         = qe;
      out_in     = dl_ff[LINE_E][DIV_LAT-1];
      out_in.x0  = tw;
      out_in.sat = out_in.sat | se;
   end

   // Advance stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.vld  <= 1'b0; s2_ff.vld  <= 1'b0; s3_ff.vld  <= 1'b0;
         s4_ff.vld  <= 1'b0; s6_ff.vld  <= 1'b0; s7_ff.vld  <= 1'b0;
         s8_ff.vld  <= 1'b0; s9_ff.vld  <= 1'b0; s11_ff.vld <= 1'b0;
         s12_ff.vld <= 1'b0; s14_ff.vld <= 1'b0; s15_ff.vld <= 1'b0;
         s16_ff.vld <= 1'b0; out_ff.vld <= 1'b0;
      end else if (en) begin
         s0_ff  <= s0_in;  s2_ff  <= s2_in;  s3_ff  <= s3_in;  s4_ff  <= s4_in;
         s6_ff  <= s6_in;  s7_ff  <= s7_in;  s8_ff  <= s8_in;  s9_ff  <= s9_in;
         s11_ff <= s11_in; s12_ff <= s12_in; s14_ff <= s14_in;
         s15_ff <= s15_in; s16_ff <= s16_in; out_ff <= out_in;
      end
   end

   // Carry the record alongside each divider
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LINES; i++) begin
            for (int k = 0; k < DIV_LAT; k++) begin
               dl_ff[i][k].vld <= 1'b0;
            end
         end
      end else if (en) begin
         for (int i = 0; i < DIV_LINES; i++) begin
            dl_ff[i][0] <= dl_in[i];
            for (int k = 1; k < DIV_LAT; k++) begin
               dl_ff[i][k] <= dl_ff[i][k-1];
            end
         end
      end
   end

   // Drop all result fields of a singular system
   assign rsp_singular     = out_ff.sing;
   assign rsp_sol0         = out_ff.sing ? '0 : out_ff.x0;
   assign rsp_sol1         = out_ff.sing ? '0 : out_ff.x1;
   assign rsp_sol2         = out_ff.sing ? '0 : out_ff.x2;
   assign rsp_det_negative = !out_ff.sing && out_ff.negdet;
   assign rsp_overflow     = !out_ff.sing && out_ff.sat;

endmodule

@@ design/solve_3x3_lu_pivot_unit.sv @@
// Top level of the pipelined 3x3 LU solver with partial pivoting.
//
//   channel   handshake           payload
//   request   req_push / req_full req_m00..req_m22, req_rhs0..req_rhs2
//   response  rsp_pop / rsp_empty rsp_sol0..2, rsp_singular, rsp_det_negative,
//                                 rsp_overflow
//
// One transaction per cycle is accepted and delivered at full rate while every
// response is popped. The pipeline runs five dependent divisions, DIV_STEP
// quotient bits per stage.
// Reset clears the queue and all pipeline valid bits.
// A response that is not popped holds the whole solver pipeline; the request
// side keeps taking transactions until the 4-entry queue fills.
`timescale 1ns / 1ps
module solve_3x3_lu_pivot_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  slu3_pkg::word_type req_m00,
   input  slu3_pkg::word_type req_m01,
   input  slu3_pkg::word_type req_m02,
   input  slu3_pkg::word_type req_m10,
   input  slu3_pkg::word_type req_m11,
   input  slu3_pkg::word_type req_m12,
   input  slu3_pkg::word_type req_m20,
   input  slu3_pkg::word_type req_m21,
   input  slu3_pkg::word_type req_m22,
   input  slu3_pkg::word_type req_rhs0,
   input  slu3_pkg::word_type req_rhs1,
   input  slu3_pkg::word_type req_rhs2,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output slu3_pkg::word_type rsp_sol0,
   output slu3_pkg::word_type rsp_sol1,
   output slu3_pkg::word_type rsp_sol2,
   output logic               rsp_singular,
   output logic               rsp_det_negative,
   output logic               rsp_overflow
);
   import slu3_pkg::*;

   front_rec_type front_rec, q_rec;
   logic          q_empty, q_pop;

   // Classify and pick the first pivot
   slu3_front u_front (
      .m00(req_m00), .m01(req_m01), .m02(req_m02),
      .m10(req_m10), .m11(req_m11), .m12(req_m12),
      .m20(req_m20), .m21(req_m21), .m22(req_m22),
      .rhs0(req_rhs0), .rhs1(req_rhs1), .rhs2(req_rhs2),
      .rec(front_rec)
   );

   // Decouple front and back
   slu3_queue u_queue (
      .clock(clock), .reset(reset),
      .push(req_push), .wdata(front_rec), .full(req_full),
      .pop(q_pop), .rdata(q_rec), .empty(q_empty)
   );

   // Solve
   slu3_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(!q_empty), .in_data(q_rec), .in_pop(q_pop),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_sol0(rsp_sol0), .rsp_sol1(rsp_sol1), .rsp_sol2(rsp_sol2),
      .rsp_singular(rsp_singular), .rsp_det_negative(rsp_det_negative),
      .rsp_overflow(rsp_overflow)
   );

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench of the pipelined 3x3 LU solver with partial pivoting.
`timescale 1ns / 1ps

// One expected or observed response transaction
typedef struct {
   logic signed [31:0] x0, x1, x2;
   logic               sing, negdet, ovf;
} solution_type;

// Holds expected solutions in order and checks each popped response.
class lu_scoreboard;
   solution_type pending[$];
   int           errors;
   bit           sat_flag;

   function new();
      errors = 0;
   endfunction

   function automatic longint lim_hi();
      return 64'sd2147483647;
   endfunction

   // Clamp a wide value into the word range and note saturation
   function automatic longint clamp(longint v);
      if (v > 64'sd2147483647) begin
         sat_flag = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat_flag = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint sub_q(longint a, longint b);
      return clamp(a - b);
   endfunction

   // Product shifted right by the fraction bits, truncated toward zero
   function automatic longint mul_q(longint a, longint b);
      logic [127:0] p;
      logic         neg;
      logic [63:0]  ma, mb;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      p   = ma * mb;
      p   = p >> 16;
      if (neg) begin
         if (p > 128'd2147483648) begin
            sat_flag = 1;
            return -64'sd2147483648;
         end
         return -$signed({1'b0, p[62:0]});
      end
      if (p > 128'd2147483647) begin
         sat_flag = 1;
         return 64'sd2147483647;
      end
      return $signed({1'b0, p[62:0]});
   endfunction

   // Numerator shifted left by the fraction bits, divided, truncated toward zero
   function automatic longint div_q(longint a, longint b);
      logic [127:0] n, q;
      logic         neg;
      logic [63:0]  ma, mb;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      if (mb == 0) return 0;
      n = {64'd0, ma} << 16;
      q = n / mb;
      if (neg) begin
         if (q > 128'd2147483648) begin
            sat_flag = 1;
            return -64'sd2147483648;
         end
         return -$signed({1'b0, q[62:0]});
      end
      if (q > 128'd2147483647) begin
         sat_flag = 1;
         return 64'sd2147483647;
      end
      return $signed({1'b0, q[62:0]});
   endfunction

   function automatic longint absq(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Work out the expected solution of one accepted system
   function void note_system(logic signed [31:0] m[9], logic signed [31:0] r[3]);
      longint       u[3][3], v[3], t[3], tv, l10, l20, l21;
      solution_type s;
      bit           neg;
      int           p;
      for (int i = 0; i < 9; i++) u[i/3][i%3] = m[i];
      for (int i = 0; i < 3; i++) v[i] = r[i];
      s = '{0, 0, 0, 0, 0, 0};
      sat_flag = 0;
      neg = 0;
      if (u[0][0] == 0 && u[1][0] == 0 && u[2][0] == 0) begin
         s.sing = 1;
         pending = {pending, s};
         return;
      end
      // First pivot: largest magnitude in column 0, ties keep the earlier row
      p = 0;
      if (absq(u[0][0]) < absq(u[1][0])) p = (absq(u[1][0]) < absq(u[2][0])) ? 2 : 1;
      else if (absq(u[0][0]) < absq(u[2][0])) p = 2;
      if (p != 0) begin
         t = u[0]; u[0] = u[p]; u[p] = t;
         tv = v[0]; v[0] = v[p]; v[p] = tv;
         neg = 1;
      end
      l10 = div_q(u[1][0], u[0][0]);
      u[1][1] = sub_q(u[1][1], mul_q(u[0][1], l10));
      u[1][2] = sub_q(u[1][2], mul_q(u[0][2], l10));
      l20 = div_q(u[2][0], u[0][0]);
      u[2][1] = sub_q(u[2][1], mul_q(u[0][1], l20));
      u[2][2] = sub_q(u[2][2], mul_q(u[0][2], l20));
      u[1][0] = l10;
      u[2][0] = l20;
      if (u[1][1] == 0 && u[2][1] == 0) begin
         s.sing = 1;
         pending = {pending, s};
         return;
      end
      // Second pivot swaps whole rows, multipliers included
      if (absq(u[1][1]) < absq(u[2][1])) begin
         t = u[1]; u[1] = u[2]; u[2] = t;
         tv = v[1]; v[1] = v[2]; v[2] = tv;
         neg = !neg;
      end
      l10 = u[1][0];
      l20 = u[2][0];
      l21 = div_q(u[2][1], u[1][1]);
      u[2][2] = sub_q(u[2][2], mul_q(u[1][2], l21));
      if (u[2][2] == 0) begin
         s.sing = 1;
         pending = {pending, s};
         return;
      end
      v[1] = sub_q(v[1], mul_q(l10, v[0]));
      v[2] = sub_q(sub_q(v[2], mul_q(l20, v[0])), mul_q(l21, v[1]));
      s.x2 = 32'(div_q(v[2], u[2][2]));
      s.x1 = 32'(div_q(sub_q(v[1], mul_q(u[1][2], s.x2)), u[1][1]));
      s.x0 = 32'(div_q(sub_q(sub_q(v[0], mul_q(u[0][1], s.x1)), mul_q(u[0][2], s.x2)),
                       u[0][0]));
      s.negdet = neg;
      s.ovf = sat_flag;
      pending = {pending, s};
   endfunction

   function void report(string f, longint e, longint a);
      $display("%0t: %s mismatch expected %0d actual %0d", $time, f, e, a);
      errors++;
   endfunction

   function void check_solution(solution_type a);
      solution_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected response sol0 %0d", $time, a.x0);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (a.x0 !== e.x0) report("sol0", e.x0, a.x0);
      if (a.x1 !== e.x1) report("sol1", e.x1, a.x1);
      if (a.x2 !== e.x2) report("sol2", e.x2, a.x2);
      if (a.sing !== e.sing) report("singular", e.sing, a.sing);
      if (a.negdet !== e.negdet) report("det_negative", e.negdet, a.negdet);
      if (a.ovf !== e.ovf) report("overflow", e.ovf, a.ovf);
   endfunction
endclass

module tb_top;
   import slu3_pkg::*;

   logic     clock = 0;
   logic     reset = 1;
   logic     req_push = 0;
   logic     req_full;
   word_type req_m[9];
   word_type req_rhs[3];
   logic     rsp_empty;
   logic     rsp_pop = 0;
   word_type rsp_sol0, rsp_sol1, rsp_sol2;
   logic     rsp_singular, rsp_det_negative, rsp_overflow;

   lu_scoreboard board = new();
   bit           quiet = 0;
   bit           feeding_done = 0;

   solve_3x3_lu_pivot_unit DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_m00(req_m[0]), .req_m01(req_m[1]), .req_m02(req_m[2]),
      .req_m10(req_m[3]), .req_m11(req_m[4]), .req_m12(req_m[5]),
      .req_m20(req_m[6]), .req_m21(req_m[7]), .req_m22(req_m[8]),
      .req_rhs0(req_rhs[0]), .req_rhs1(req_rhs[1]), .req_rhs2(req_rhs[2]),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_sol0(rsp_sol0), .rsp_sol1(rsp_sol1), .rsp_sol2(rsp_sol2),
      .rsp_singular(rsp_singular), .rsp_det_negative(rsp_det_negative),
      .rsp_overflow(rsp_overflow)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   initial begin
      for (int i = 0; i < 9; i++) req_m[i] = '0;
      for (int i = 0; i < 3; i++) req_rhs[i] = '0;
   end

   // Random word: mix of full-range, small Q values and extremes
   function automatic word_type pick_word();
      case ($urandom_range(0, 9))
         0:       return word_type'(32'h8000_0000);
         1:       return word_type'(32'h7FFF_FFFF);
         2:       return '0;
         3, 4:    return word_type'($urandom());
         default: return word_type'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
      endcase
   endfunction

   // Drive one system and hold it until the block takes it
   task automatic push_system(word_type m[9], word_type r[3]);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_push <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_push <= 1;
      for (int i = 0; i < 9; i++) req_m[i] <= m[i];
      for (int i = 0; i < 3; i++) req_rhs[i] <= r[i];
      do @(posedge clock); while (req_full);
      board.note_system(m, r);
   endtask

   task automatic push_simple(word_type a, word_type b, word_type c, word_type d,
                              word_type e, word_type f, word_type g, word_type h,
                              word_type k, word_type r0, word_type r1, word_type r2);
      word_type m[9];
      word_type r[3];
      m = '{a, b, c, d, e, f, g, h, k};
      r = '{r0, r1, r2};
      push_system(m, r);
   endtask

   // Pop responses, stalling in random bursts
   initial begin
      solution_type got;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            got.x0 = rsp_sol0; got.x1 = rsp_sol1; got.x2 = rsp_sol2;
            got.sing = rsp_singular; got.negdet = rsp_det_negative;
            got.ovf = rsp_overflow;
            board.check_solution(got);
         end
         if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_pop <= 0;
            repeat ($urandom_range(1, 12) - 1) @(posedge clock);
         end else begin
            rsp_pop <= 1;
         end
      end
   end

   // Stimulus
   initial begin
      word_type m[9];
      word_type r[3];
      localparam word_type ONE = 32'sh0001_0000;
      localparam word_type MN = 32'sh8000_0000;
      localparam word_type MX = 32'sh7FFF_FFFF;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Identity, swaps, ties, singular cases, extremes
      push_simple(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, ONE, -ONE, 3 * ONE);
      push_simple(0, ONE, 0, ONE, 0, 0, 0, 0, ONE, ONE, 2 * ONE, 3 * ONE);
      push_simple(ONE, 0, 0, 2 * ONE, ONE, 0, 3 * ONE, 0, ONE, ONE, ONE, ONE);
      push_simple(ONE, 2, 3, -ONE, 5, 6, ONE, 8, 9, ONE, ONE, ONE);
      push_simple(0, ONE, 2, 0, 3, 4, 0, 5, 6, ONE, ONE, ONE);
      push_simple(ONE, ONE, ONE, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 3 * ONE, 1, 2, 3);
      push_simple(ONE, 0, 0, 0, ONE, ONE, 0, ONE, ONE, 1, 2, 3);
      push_simple(0, 0, ONE, 0, ONE, 0, ONE, 0, 0, 4, 5, 6);
      push_simple(ONE, 0, 0, 0, 0, ONE, 0, ONE, 0, 4, 5, 6);
      push_simple(MN, MX, MN, MX, MN, MX, MN, MX, MN, MX, MN, MX);
      push_simple(MX, MX, MX, MX, MN, MX, MX, MX, MN, MN, MN, MN);
      push_simple(1, 0, 0, 0, 1, 0, 0, 0, 1, MX, MN, MX);
      push_simple(MN, 0, 0, 0, MN, 0, 0, 0, MN, 1, -1, MX);
      push_simple(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
      push_simple(0, 0, 0, 0, 0, 0, 0, 0, 0, MX, MX, MX);
      push_simple(2, ONE, 0, -2, 0, ONE, 2, 0, 0, ONE, ONE, ONE);
      for (int n = 0; n < 600; n++) begin
         if (n == 520) quiet = 1;
         for (int i = 0; i < 9; i++) m[i] = pick_word();
         for (int i = 0; i < 3; i++) r[i] = pick_word();
         // Occasionally force a dependent row, a zero column or a column-0 magnitude tie
         case ($urandom_range(0, 15))
            0: begin m[6] = m[3]; m[7] = m[4]; m[8] = m[5]; end
            1: begin m[0] = 0; m[3] = 0; m[6] = 0; end
            2: m[3] = -m[0];
            default: ;
         endcase
         push_system(m, r);
      end
      req_push <= 0;
      feeding_done = 1;
   end

   // Drain and report
   initial begin
      wait (feeding_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #400000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

@@ files.f @@
design/slu3_pkg.sv
design/slu3_front.sv
design/slu3_queue.sv
design/slu3_div.sv
design/slu3_back.sv
design/solve_3x3_lu_pivot_unit.sv
dv/tb_top.sv
